// ----- sv/lvr_pkg.sv -----
`default_nettype none
package lvr_pkg;

    localparam int PARTICLES = 64;

    localparam int WEIGHT_W = 16;
    localparam int OFFSET_W = 16;
    localparam int INDEX_W  = 6;
    localparam int TOTAL_W  = 22;

    localparam int IDX_W    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CNT_W    = $clog2(PARTICLES + 1);
    localparam int BANKS    = 2;
    localparam int DEPTH    = BANKS * (1 << IDX_W);
    localparam int ADDR_W   = IDX_W + 1;

    // pointer side: ((m << 16) + offset) * total, kept incrementally
    localparam int PTR_W    = CNT_W + OFFSET_W + TOTAL_W;
    // bin side: cum * n, compared after a shift by the fraction width
    localparam int CUMN_W   = TOTAL_W + CNT_W;

    typedef struct packed {
        logic [CNT_W-1:0]    n;
        logic [TOTAL_W-1:0]  total;
        logic [OFFSET_W-1:0] offset;
    } job_t;

    typedef struct packed {
        logic en;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        logic full;
        logic bank;
        logic wr_bank;
        job_t job;
    } head_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [WEIGHT_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_stat_t;

endpackage
`default_nettype wire

// ----- sv/lvr_load_if.sv -----
`default_nettype none
interface lvr_load_if;
    import lvr_pkg::*;

    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    logic [OFFSET_W-1:0] offset;
    logic                last;

    modport source (output valid, output weight, output offset, output last, input ready);
    modport sink   (input valid, input weight, input offset, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/lvr_result_if.sv -----
`default_nettype none
interface lvr_result_if;
    import lvr_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic               final_res;

    modport source (output valid, output index, output final_res, input ready);
    modport sink   (input valid, input index, input final_res, output ready);
endinterface
`default_nettype wire

// ----- sv/lvr_queue.sv -----
`default_nettype none
module lvr_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lvr_pkg::push_t  push,
    input  wire logic            pop,
    output lvr_pkg::head_t       head
);
    import lvr_pkg::*;

    // one entry per store bank: entry k describes the run held in bank k
    job_t       ent_reg [BANKS];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       wr_reg;
    logic       rd_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.en && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push.en && pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.en)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
        begin
            ent_reg[wr_reg] <= push.job;
        end
    end

    assign head.valid   = (cnt_reg != 2'd0);
    assign head.full    = (cnt_reg == 2'(BANKS));
    assign head.bank    = rd_reg;
    assign head.wr_bank = wr_reg;
    assign head.job     = ent_reg[rd_reg];

endmodule
`default_nettype wire

// ----- sv/lvr_front.sv -----
`default_nettype none
module lvr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lvr_load_if.sink            load,
    input  wire lvr_pkg::head_t head,
    output lvr_pkg::push_t      push,
    output lvr_pkg::store_wr_t  store_wr
);
    import lvr_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               accept;
    logic               room;
    logic [CNT_W-1:0]   count_upd;
    logic [TOTAL_W-1:0] total_upd;

    // loading needs a free bank; the bank being filled is the queue's write slot
    assign load.ready = !head.full;
    assign accept     = load.valid && load.ready;
    assign room       = (count_reg < CNT_W'(PARTICLES));

    always_comb
    begin
        count_upd = count_reg;
        total_upd = total_reg;
        if (room)
        begin
            count_upd = count_reg + CNT_W'(1);
            total_upd = total_reg + TOTAL_W'(load.weight);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (accept)
        begin
            if (load.last)
            begin
                count_next = '0;
                total_next = '0;
            end
            else
            begin
                count_next = count_upd;
                total_next = total_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    assign store_wr.en   = accept && room;
    assign store_wr.addr = {head.wr_bank, count_reg[IDX_W-1:0]};
    assign store_wr.data = load.weight;

    assign push.en         = accept && load.last;
    assign push.job.n      = count_upd;
    assign push.job.total  = total_upd;
    assign push.job.offset = load.offset;

endmodule
`default_nettype wire

// ----- sv/lvr_back.sv -----
`default_nettype none
module lvr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lvr_pkg::head_t     head,
    input  wire lvr_pkg::store_wr_t store_wr,
    output lvr_pkg::back_stat_t     stat,
    lvr_result_if.source            result
);
    import lvr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK
    } state_t;

    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [WEIGHT_W-1:0] rdata_reg;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    m_reg, m_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [CUMN_W-1:0]   cumn_reg, cumn_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                out_final_reg, out_final_next;

    logic [CNT_W-1:0]    rd_idx;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    i_plus1;
    logic [CNT_W-1:0]    m_plus1;
    logic                zero_total;
    logic                more;
    logic                advance;
    logic                out_free;
    logic                is_final;
    logic                pop;
    logic [WEIGHT_W+CNT_W-1:0] wn_prod;
    logic [OFFSET_W+TOTAL_W-1:0] start_prod;

    assign i_plus1    = {1'b0, i_reg} + CNT_W'(1);
    assign m_plus1    = {1'b0, m_reg} + CNT_W'(1);
    assign zero_total = (head.job.total == '0);
    assign more       = (i_plus1 < head.job.n);
    assign advance    = !zero_total && more && (ptr_reg > {cumn_reg, {OFFSET_W{1'b0}}});
    assign out_free   = !out_valid_reg || result.ready;
    assign is_final   = (m_plus1 == head.job.n);
    assign wn_prod    = rdata_reg * head.job.n;
    assign start_prod = head.job.offset * head.job.total;

    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        ptr_next       = ptr_reg;
        cumn_next      = cumn_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_index_next = out_index_reg;
        out_final_next = out_final_reg;
        rd_idx         = '0;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // read of weight 0 is already under way
                if (head.valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                m_next     = '0;
                i_next     = '0;
                ptr_next   = PTR_W'(start_prod);
                cumn_next  = CUMN_W'(wn_prod);
                rd_idx     = CNT_W'(1);
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // rdata_reg holds the weight of bin i+1
                if (advance)
                begin
                    i_next    = i_plus1[IDX_W-1:0];
                    cumn_next = cumn_reg + CUMN_W'(wn_prod);
                    rd_idx    = i_plus1 + CNT_W'(1);
                end
                else
                begin
                    rd_idx = i_plus1;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = zero_total ? INDEX_W'(m_reg) : INDEX_W'(i_reg);
                        out_final_next = is_final;
                        m_next         = m_plus1[IDX_W-1:0];
                        ptr_next       = ptr_reg + PTR_W'({head.job.total, {OFFSET_W{1'b0}}});
                        if (is_final)
                        begin
                            pop        = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = {head.bank, rd_idx[IDX_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        i_reg         <= i_next;
        ptr_reg       <= ptr_next;
        cumn_reg      <= cumn_next;
        out_index_reg <= out_index_next;
        out_final_reg <= out_final_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            mem[store_wr.addr] <= store_wr.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.pop  = pop;

    assign result.valid     = out_valid_reg;
    assign result.index     = out_index_reg;
    assign result.final_res = out_final_reg;

endmodule
`default_nettype wire

// ----- sv/low_variance_resampler.sv -----
`default_nettype none
// channel  | role | handshake     | payload
// ---------+------+---------------+-------------------------------
// load     | sink | valid / ready | weight[15:0] offset[15:0] last
// result   | src  | valid / ready | index[5:0] final_res
//
// A weight beat is written to the store in the cycle it is accepted. A run
// marked last is walked one compare and add per cycle in the walker while
// result is not stalled, limited by its single store read port.
// Two store banks let the next run load while the current one is walked;
// load.ready drops only while both banks hold runs. result holds while
// stalled. Reset clears counts, totals and the run queue; no clearing pass.
module low_variance_resampler (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lvr_load_if.sink     load,
    lvr_result_if.source result
);
    import lvr_pkg::*;

    push_t      push;
    head_t      head;
    store_wr_t  store_wr;
    back_stat_t stat;

    lvr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .head     (head),
        .push     (push),
        .store_wr (store_wr)
    );

    lvr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (stat.pop),
        .head  (head)
    );

    lvr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .store_wr (store_wr),
        .stat     (stat),
        .result   (result)
    );

    a_busy_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> head.valid)
        else $error("walker busy without a queued run");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.en |-> !head.full)
        else $error("run pushed into a full queue");

    a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (store_wr.en && head.valid) |-> (store_wr.addr[ADDR_W-1] != head.bank))
        else $error("load wrote the bank under walk");

    a_final_pops: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |=> (result.valid && result.final_res))
        else $error("run retired without a final beat");

endmodule
`default_nettype wire
